FILE: src/scht_pkg.sv
`timescale 1ns / 1ps

package scht_pkg;

   localparam int COORD_W  = 4;
   localparam int HEIGHT_W = 16;
   localparam int POS_W    = 10;
   localparam int MCOUNT_W = 11;

   typedef enum logic [1:0] {
      OP_CELL_LOOKUP  = 2'd0,
      OP_ENTRY_LOOKUP = 2'd1,
      OP_INSERT       = 2'd2,
      OP_DELETE       = 2'd3
   } scht_op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } scht_status_type;

   // per-cell compare results, handed to the right-hand neighbor and to the tree
   typedef struct packed {
      logic precedes;   // entry sorts before the request
      logic key_lt;     // entry key below the request key
      logic key_le;     // entry key not above the request key
      logic lower_bnd;  // first cell not before the request
      logic first_bnd;  // first cell not below the requested key
      logic end_bnd;    // first cell past the requested key
      logic exact_hit;  // boundary cell holds the exact entry
   } scht_flags_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } scht_cmd_type;

endpackage

FILE: src/scht_cell.sv
`timescale 1ns / 1ps

module scht_cell #(
   parameter int KEY_W = 8,
   parameter int CNT_W = 11,
   parameter int INDEX = 0
) (
   input  logic                                  clock,
   input  logic [KEY_W-1:0]                      req_key,
   input  logic signed [scht_pkg::HEIGHT_W-1:0]  req_height,
   input  logic [CNT_W-1:0]                      count,
   input  logic [KEY_W-1:0]                      left_key,
   input  logic signed [scht_pkg::HEIGHT_W-1:0]  left_height,
   input  logic [KEY_W-1:0]                      right_key,
   input  logic signed [scht_pkg::HEIGHT_W-1:0]  right_height,
   input  scht_pkg::scht_flags_type              prev_flags,
   input  scht_pkg::scht_cmd_type                cmd,
   output logic [KEY_W-1:0]                      key,
   output logic signed [scht_pkg::HEIGHT_W-1:0]  height,
   output scht_pkg::scht_flags_type              flags
);
   import scht_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [KEY_W-1:0]           key_ff;
   logic signed [HEIGHT_W-1:0] height_ff;
   logic                       occupied;
   logic                       key_eq;
   logic                       height_eq;

   assign occupied  = MY_POS < count;
   assign key_eq    = key_ff == req_key;
   assign height_eq = height_ff == req_height;

   always_comb begin
      flags.key_lt    = occupied && (key_ff < req_key);
      flags.key_le    = occupied && (key_ff <= req_key);
      flags.precedes  = occupied && ((key_ff < req_key) || (key_eq && (height_ff < req_height)));
      flags.lower_bnd = !flags.precedes && prev_flags.precedes;
      flags.first_bnd = !flags.key_lt && prev_flags.key_lt;
      flags.end_bnd   = !flags.key_le && prev_flags.key_le;
      flags.exact_hit = flags.lower_bnd && occupied && key_eq && height_eq;
   end

   // insert: cells at and behind the slot move right; delete: they move left
   always_ff @(posedge clock) begin
      if (cmd.ins && !flags.precedes) begin
         if (prev_flags.precedes) begin
            key_ff    <= req_key;
            height_ff <= req_height;
         end else begin
            key_ff    <= left_key;
            height_ff <= left_height;
         end
      end else if (cmd.del && !flags.precedes) begin
         key_ff    <= right_key;
         height_ff <= right_height;
      end
   end

   assign key    = key_ff;
   assign height = height_ff;

endmodule

FILE: src/sorted_cell_height_table_core.sv
`timescale 1ns / 1ps

// Sorted table of (cell key, signed height) entries, cell key = cell_z * CELLS_PER_SIDE
// + cell_x, ordered by key and then height. Each entry lives in a cell of a chain;
// every cell compares itself against the request at once, and an insert or delete
// moves all cells behind the slot one place together. Positions are found
// by a registered radix-4 tree over the cell boundaries, ceil(log2(MAX_ENTRIES)/2)
// levels deep. One transaction is in flight at a time: after acceptance it waits in
// ST_RUN while the tree settles, then ST_DONE commits the shift and the response
// together once the response side is free; then a new request is taken. A finished
// response waits in an output register. There is no clearing pass after reset.
module sorted_cell_height_table_core #(
   parameter int CELLS_PER_SIDE = 16,
   parameter int MAX_ENTRIES    = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  scht_pkg::scht_op_type                 req_operation,
   input  logic [scht_pkg::COORD_W-1:0]          req_cell_x,
   input  logic [scht_pkg::COORD_W-1:0]          req_cell_z,
   input  logic signed [scht_pkg::HEIGHT_W-1:0]  req_height,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output scht_pkg::scht_status_type             rsp_status,
   output logic [scht_pkg::POS_W-1:0]            rsp_position,
   output logic [scht_pkg::MCOUNT_W-1:0]         rsp_match_count
);
   import scht_pkg::*;

   // widths that follow from the parameters
   localparam int KEY_W     = $clog2(15 * CELLS_PER_SIDE + 16);
   localparam int IDX_W     = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int LEVELS    = (IDX_W + 1) / 2;
   localparam int LEAVES    = 4 ** LEVELS;
   localparam int LEAF_BASE = (LEAVES - 1) / 3;
   localparam int NODES     = LEAF_BASE + LEAVES;
   localparam int WAIT_W    = $clog2(LEVELS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

   // boundary positions; at most one cell raises each boundary so an OR encodes it
   typedef struct packed {
      logic [IDX_W-1:0] lower_idx;
      logic [IDX_W-1:0] first_idx;
      logic [IDX_W-1:0] end_idx;
      logic             lower_hit;
      logic             first_hit;
      logic             end_hit;
      logic             exact;
   } node_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                  state_ff;
   logic [WAIT_W-1:0]          wait_ff;
   logic [CNT_W-1:0]           count_ff;
   logic                       rsp_valid_ff;
   scht_status_type            rsp_status_ff;
   logic [POS_W-1:0]           rsp_position_ff;
   logic [MCOUNT_W-1:0]        rsp_match_count_ff;

   // held request
   scht_op_type                op_ff;
   logic [KEY_W-1:0]           key_ff;
   logic signed [HEIGHT_W-1:0] height_ff;
   logic [KEY_W-1:0]           key_in;

   // cell chain
   logic [KEY_W-1:0]           cell_key    [MAX_ENTRIES];
   logic signed [HEIGHT_W-1:0] cell_height [MAX_ENTRIES];
   scht_flags_type             cell_flags  [MAX_ENTRIES];
   scht_flags_type             head_flags;
   scht_cmd_type               cmd;

   // position tree
   node_type                   tree_node [NODES];
   node_type                   tree_ff   [LEAF_BASE];
   node_type                   root;

   // result
   logic [CNT_W-1:0]           lower_pos;
   logic [CNT_W-1:0]           first_pos;
   logic [CNT_W-1:0]           end_pos;
   logic [CNT_W-1:0]           run_len;
   scht_status_type            res_status;
   logic [CNT_W-1:0]           res_pos;
   logic [CNT_W-1:0]           res_count;
   logic                       commit;
   logic                       do_insert;
   logic                       do_delete;

   // nothing is taken while reset is held
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign key_in    = KEY_W'(req_cell_z) * KEY_W'(CELLS_PER_SIDE) + KEY_W'(req_cell_x);

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff     <= req_operation;
         key_ff    <= key_in;
         height_ff <= req_height;
      end
   end

   // everything ahead of cell 0 sorts before the request
   assign head_flags = '{precedes: 1'b1, key_lt: 1'b1, key_le: 1'b1, default: 1'b0};

   genvar gi;
   generate
      for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
         if (gi < MAX_ENTRIES) begin : g_cell
            scht_cell #(
               .KEY_W (KEY_W),
               .CNT_W (CNT_W),
               .INDEX (gi)
            ) u_cell (
               .clock        (clock),
               .req_key      (key_ff),
               .req_height   (height_ff),
               .count        (count_ff),
               .left_key     (cell_key[(gi == 0) ? 0 : gi - 1]),
               .left_height  (cell_height[(gi == 0) ? 0 : gi - 1]),
               .right_key    (cell_key[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
               .right_height (cell_height[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
               .prev_flags   ((gi == 0) ? head_flags : cell_flags[(gi == 0) ? 0 : gi - 1]),
               .cmd          (cmd),
               .key          (cell_key[gi]),
               .height       (cell_height[gi]),
               .flags        (cell_flags[gi])
            );

            always_comb begin
               tree_node[LEAF_BASE + gi].lower_idx =
                  {IDX_W{cell_flags[gi].lower_bnd}} & IDX_W'(gi);
               tree_node[LEAF_BASE + gi].first_idx =
                  {IDX_W{cell_flags[gi].first_bnd}} & IDX_W'(gi);
               tree_node[LEAF_BASE + gi].end_idx =
                  {IDX_W{cell_flags[gi].end_bnd}} & IDX_W'(gi);
               tree_node[LEAF_BASE + gi].lower_hit = cell_flags[gi].lower_bnd;
               tree_node[LEAF_BASE + gi].first_hit = cell_flags[gi].first_bnd;
               tree_node[LEAF_BASE + gi].end_hit   = cell_flags[gi].end_bnd;
               tree_node[LEAF_BASE + gi].exact     = cell_flags[gi].exact_hit;
            end
         end else begin : g_pad
            assign tree_node[LEAF_BASE + gi] = '0;
         end
      end

      // internal nodes, one register level per tree level
      for (gi = 0; gi < LEAF_BASE; gi++) begin : g_node
         always_ff @(posedge clock) begin
            tree_ff[gi] <= node_type'(tree_node[4 * gi + 1] | tree_node[4 * gi + 2] |
                                      tree_node[4 * gi + 3] | tree_node[4 * gi + 4]);
         end
         assign tree_node[gi] = tree_ff[gi];
      end
   endgenerate

   assign root = tree_ff[0];

   // a missing boundary means every occupied cell lies before it
   assign lower_pos = root.lower_hit ? CNT_W'(root.lower_idx) : count_ff;
   assign first_pos = root.first_hit ? CNT_W'(root.first_idx) : count_ff;
   assign end_pos   = root.end_hit   ? CNT_W'(root.end_idx)   : count_ff;
   assign run_len   = end_pos - first_pos;

   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      res_status = STATUS_NOT_FOUND;
      res_pos    = '0;
      res_count  = '0;
      do_insert  = 1'b0;
      do_delete  = 1'b0;
      unique case (op_ff)
         OP_CELL_LOOKUP: begin
            if (run_len != '0) begin
               res_status = STATUS_OK;
               res_pos    = first_pos;
               res_count  = run_len;
            end
         end
         OP_ENTRY_LOOKUP: begin
            if (root.exact) begin
               res_status = STATUS_OK;
               res_pos    = lower_pos;
            end
         end
         OP_INSERT: begin
            // duplicate check ranks above the full check
            priority if (root.exact) begin
               res_status = STATUS_DUPLICATE;
               res_pos    = lower_pos;
            end else if (count_ff == FULL_COUNT) begin
               res_status = STATUS_FULL;
            end else begin
               res_status = STATUS_OK;
               res_pos    = lower_pos;
               do_insert  = commit;
            end
         end
         OP_DELETE: begin
            if (root.exact) begin
               res_status = STATUS_OK;
               res_pos    = lower_pos;
               do_delete  = commit;
            end
         end
         default: begin
            res_status = STATUS_NOT_FOUND;
         end
      endcase
   end

   assign cmd = '{ins: do_insert, del: do_delete};

   // sequencer: wait for the tree, then commit the shift and the response together
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response replacing the one just taken keeps valid high
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_RUN;
                  wait_ff  <= WAIT_W'(LEVELS);
               end
            end
            ST_RUN: begin
               wait_ff <= wait_ff - WAIT_W'(1);
               if (wait_ff == WAIT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (commit) begin
                  state_ff           <= ST_IDLE;
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= res_status;
                  rsp_position_ff    <= POS_W'(res_pos);
                  rsp_match_count_ff <= MCOUNT_W'(res_count);
                  if (do_insert) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else if (do_delete) begin
                     count_ff <= count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_match_count = rsp_match_count_ff;

   // entry count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table size");

   // an insert grows the table by exactly one entry
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow entry count");

   // a delete shrinks the table by exactly one entry
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      do_delete |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shrink entry count");

   // without a shift the entry count holds
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(do_insert || do_delete) |=> $stable(count_ff))
      else $error("entry count changed without a shift");

   // a shift only happens with a response being issued
   a_shift_commit: assert property (@(posedge clock) disable iff (reset)
      (do_insert || do_delete) |=> rsp_valid_ff && (rsp_status_ff == STATUS_OK))
      else $error("table shift without ok response");

endmodule

FILE: tb/sv/tb_sorted_cell_height_table_core.sv
`timescale 1ns / 1ps

module tb_sorted_cell_height_table_core;
   import scht_pkg::*;

   localparam int CELLS          = 16;
   localparam int DEPTH          = 1024;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any accepted transaction
   localparam int DRAIN_CYCLES   = 20;     // clocks run after the last expected result is seen

   // one result of the table, field for field as the rsp_ ports carry it
   typedef struct packed {
      scht_status_type       status;
      logic [POS_W-1:0]      position;
      logic [MCOUNT_W-1:0]   match_count;
   } table_result_type;

   // one row of the directed table; typed marks rows whose result is written out by hand
   typedef struct packed {
      scht_op_type              op;
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       z;
      logic signed [HEIGHT_W-1:0] h;
      logic                     typed;
      scht_status_type          status;
      logic [POS_W-1:0]         position;
      logic [MCOUNT_W-1:0]      match_count;
   } table_stim_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   scht_op_type                  req_operation;
   logic [COORD_W-1:0]           req_cell_x;
   logic [COORD_W-1:0]           req_cell_z;
   logic signed [HEIGHT_W-1:0]   req_height;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   scht_status_type              rsp_status;
   logic [POS_W-1:0]             rsp_position;
   logic [MCOUNT_W-1:0]          rsp_match_count;

   // shadow copy of the sorted table, kept in step with every accepted request
   int                           shadow_key [DEPTH];
   int                           shadow_height [DEPTH];
   int                           shadow_count;
   int                           peak_count;

   table_result_type             pending_results [$];
   table_stim_type               directed_stim [24];

   int                           req_gap_pct;
   int                           rsp_stall_pct;
   int                           failures;
   int                           req_count;
   int                           status_seen [4];
   int                           idle_cycles;

   // hot cells and heights so that lookups, duplicates and deletes actually hit
   logic [COORD_W-1:0]           hot_x [4];
   logic [COORD_W-1:0]           hot_z [4];
   logic signed [HEIGHT_W-1:0]   hot_h [4];

   sorted_cell_height_table_core #(
      .CELLS_PER_SIDE (CELLS),
      .MAX_ENTRIES    (DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_cell_x      (req_cell_x),
      .req_cell_z      (req_cell_z),
      .req_height      (req_height),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // carry out one operation on the shadow table and return the result it owes
   function automatic table_result_type apply_table_op(scht_op_type op,
                                                       logic [COORD_W-1:0] x,
                                                       logic [COORD_W-1:0] z,
                                                       logic signed [HEIGHT_W-1:0] h);
      table_result_type res;
      int            key;
      int            hv;
      int            slot;
      int            n;
      bit            exact;
      res.status      = STATUS_NOT_FOUND;
      res.position    = '0;
      res.match_count = '0;
      key = int'(z) * CELLS + int'(x);
      hv  = int'(h);

      if (op == OP_CELL_LOOKUP) begin
         slot = 0;
         while (slot < shadow_count && shadow_key[slot] < key) slot++;
         n = 0;
         while (slot + n < shadow_count && shadow_key[slot + n] == key) n++;
         // an empty cell reads as not found
         if (n > 0) begin
            res.status      = STATUS_OK;
            res.position    = POS_W'(slot);
            res.match_count = MCOUNT_W'(n);
         end
         return res;
      end

      // first slot not sorting before (key, height)
      slot = 0;
      while (slot < shadow_count && (shadow_key[slot] < key ||
             (shadow_key[slot] == key && shadow_height[slot] < hv))) slot++;
      exact = slot < shadow_count && shadow_key[slot] == key && shadow_height[slot] == hv;

      case (op)
         OP_ENTRY_LOOKUP: begin
            if (exact) begin
               res.status   = STATUS_OK;
               res.position = POS_W'(slot);
            end
         end
         OP_INSERT: begin
            // a clashing height wins over a full table
            if (exact) begin
               res.status   = STATUS_DUPLICATE;
               res.position = POS_W'(slot);
            end else if (shadow_count >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (int j = shadow_count; j > slot; j--) begin
                  shadow_key[j]    = shadow_key[j - 1];
                  shadow_height[j] = shadow_height[j - 1];
               end
               shadow_key[slot]    = key;
               shadow_height[slot] = hv;
               shadow_count++;
               res.status   = STATUS_OK;
               res.position = POS_W'(slot);
            end
         end
         default: begin
            if (exact) begin
               for (int j = slot; j < shadow_count - 1; j++) begin
                  shadow_key[j]    = shadow_key[j + 1];
                  shadow_height[j] = shadow_height[j + 1];
               end
               shadow_count--;
               res.status   = STATUS_OK;
               res.position = POS_W'(slot);
            end
         end
      endcase
      return res;
   endfunction

   // drive one request, wait for it to be taken, then log what it must produce
   task automatic issue_request(scht_op_type op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] z,
                                logic signed [HEIGHT_W-1:0] h, logic typed,
                                table_result_type typed_result);
      table_result_type predicted;
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_cell_x    <= x;
      req_cell_z    <= z;
      req_height    <= h;
      do @(posedge clock); while (req_stall);
      // the shadow table moves on either way, typed rows only swap the expectation
      predicted = apply_table_op(op, x, z, h);
      pending_results.push_back(typed ? typed_result : predicted);
      req_count++;
      if (shadow_count > peak_count) peak_count = shadow_count;
   endtask

   // an entry that is present in the table right now
   task automatic pick_entry(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] z,
                             output logic signed [HEIGHT_W-1:0] h);
      int idx;
      idx = $urandom_range(shadow_count - 1);
      x = COORD_W'(shadow_key[idx] % CELLS);
      z = COORD_W'(shadow_key[idx] / CELLS);
      h = HEIGHT_W'(shadow_height[idx]);
   endtask

   task automatic shuffle_hot_set();
      for (int k = 0; k < 4; k++) begin
         hot_x[k] = COORD_W'($urandom_range(15));
         hot_z[k] = COORD_W'($urandom_range(15));
         hot_h[k] = HEIGHT_W'($urandom());
      end
   endtask

   // mostly inserts and deletes on a few hot cells, with lookups and stray full-range items
   task automatic send_random_mixed();
      int                         r;
      scht_op_type                op;
      logic [COORD_W-1:0]         x;
      logic [COORD_W-1:0]         z;
      logic signed [HEIGHT_W-1:0] h;
      r  = $urandom_range(99);
      op = scht_op_type'((r < 35) ? OP_INSERT : (r < 60) ? OP_DELETE :
                         (r < 80) ? OP_ENTRY_LOOKUP : OP_CELL_LOOKUP);
      if (op != OP_INSERT && shadow_count > 0 && $urandom_range(1) == 1) begin
         pick_entry(x, z, h);
      end else begin
         x = ($urandom_range(3) != 0) ? hot_x[$urandom_range(3)] : COORD_W'($urandom_range(15));
         z = ($urandom_range(3) != 0) ? hot_z[$urandom_range(3)] : COORD_W'($urandom_range(15));
         case ($urandom_range(3))
            0: h = $urandom_range(1) ? 16'h8000 : 16'h7FFF;   // height extremes
            3: h = HEIGHT_W'($urandom());
            default: h = hot_h[$urandom_range(3)];
         endcase
      end
      issue_request(op, x, z, h, 1'b0, '0);
   endtask

   // response side: check against the oldest expectation, then roll the next stall
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing outstanding: status %0d position %0d count %0d",
                     $time, rsp_status, rsp_position, rsp_match_count);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_status);
               failures++;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position mismatch: expected %0d, got %0d",
                        $time, want.position, rsp_position);
               failures++;
            end
            if (rsp_match_count !== want.match_count) begin
               $display("%0t: match_count mismatch: expected %0d, got %0d",
                        $time, want.match_count, rsp_match_count);
               failures++;
            end
         end
      end
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog: a long stretch with no transaction on either side means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still outstanding",
                  $time, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      table_result_type           typed_result;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_CELL_LOOKUP;
      req_cell_x    = '0;
      req_cell_z    = '0;
      req_height    = '0;
      idle_cycles   = 0;
      shadow_count  = 0;
      peak_count    = 0;
      failures      = 0;
      req_count     = 0;
      for (int k = 0; k < 4; k++) status_seen[k] = 0;

      // directed rows: empty table, corner cells, height extremes, every status but full
      directed_stim = '{
         '{OP_CELL_LOOKUP,  4'd0,  4'd0,  16'h0000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_ENTRY_LOOKUP, 4'd15, 4'd15, 16'h8000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_DELETE,       4'd3,  4'd4,  16'h0000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_INSERT,       4'd0,  4'd0,  16'h8000, 1'b1, STATUS_OK,        10'd0, 11'd0},
         '{OP_INSERT,       4'd15, 4'd15, 16'h7FFF, 1'b1, STATUS_OK,        10'd1, 11'd0},
         '{OP_INSERT,       4'd0,  4'd0,  16'h8000, 1'b1, STATUS_DUPLICATE, 10'd0, 11'd0},
         '{OP_INSERT,       4'd15, 4'd15, 16'h8000, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_INSERT,       4'd15, 4'd15, 16'h0000, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_INSERT,       4'd0,  4'd0,  16'h7FFF, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_INSERT,       4'd0,  4'd0,  16'hFFFF, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_CELL_LOOKUP,  4'd0,  4'd0,  16'h0000, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_CELL_LOOKUP,  4'd15, 4'd15, 16'h1234, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_ENTRY_LOOKUP, 4'd15, 4'd15, 16'h0000, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_ENTRY_LOOKUP, 4'd0,  4'd0,  16'h0001, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_CELL_LOOKUP,  4'd7,  4'd7,  16'h0000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_INSERT,       4'd8,  4'd3,  16'h0064, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_DELETE,       4'd0,  4'd0,  16'h8000, 1'b1, STATUS_OK,        10'd0, 11'd0},
         '{OP_DELETE,       4'd0,  4'd0,  16'h8000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_CELL_LOOKUP,  4'd8,  4'd3,  16'hFFFF, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_DELETE,       4'd15, 4'd15, 16'h7FFF, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_ENTRY_LOOKUP, 4'd8,  4'd3,  16'h0064, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_ENTRY_LOOKUP, 4'd15, 4'd15, 16'h7FFF, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0},
         '{OP_INSERT,       4'd7,  4'd9,  16'hCFC7, 1'b0, STATUS_OK,        10'd0, 11'd0},
         '{OP_CELL_LOOKUP,  4'd15, 4'd0,  16'h0000, 1'b1, STATUS_NOT_FOUND, 10'd0, 11'd0}
      };

      // light sender gaps, heavy receiver stalls to start with
      req_gap_pct   = 8;
      rsp_stall_pct = 69;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_stim[i]) begin
         typed_result.status      = directed_stim[i].status;
         typed_result.position    = directed_stim[i].position;
         typed_result.match_count = directed_stim[i].match_count;
         issue_request(directed_stim[i].op, directed_stim[i].x, directed_stim[i].z,
                       directed_stim[i].h, directed_stim[i].typed, typed_result);
      end

      // mixed traffic on hot cells, first with the receiver as the bottleneck
      shuffle_hot_set();
      repeat (200) send_random_mixed();

      // then the sender is the slow one
      req_gap_pct   = 69;
      rsp_stall_pct = 8;
      shuffle_hot_set();
      repeat (200) send_random_mixed();

      // full speed on both sides
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      shuffle_hot_set();
      repeat (100) send_random_mixed();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests, table occupancy peaked at %0d of %0d entries",
               req_count, peak_count, DEPTH);
      $display("responses seen: ok %0d, not found %0d, duplicate %0d, full %0d",
               status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND],
               status_seen[STATUS_DUPLICATE], status_seen[STATUS_FULL]);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
